FILE: rtl/tsme_pkg.sv
// ----------------------------------------------------------------------------
// tsme_pkg
// shared types and constants for the two-set membership engine
// ----------------------------------------------------------------------------
package tsme_pkg;

    localparam int DATA_W           = 32;
    localparam int SET_CAPACITY_DEF = 16;
    localparam int MAX_RESULTS      = 32;
    localparam int COUNT_OUT_W      = 5;

    typedef enum logic [3:0] {
        OP_INSERT    = 4'd0,
        OP_MEMBER    = 4'd1,
        OP_CLEAR     = 4'd2,
        OP_UNION     = 4'd3,
        OP_INTERSECT = 4'd4,
        OP_A_MINUS_B = 4'd5,
        OP_SYMDIFF   = 4'd6,
        OP_SUBSET    = 4'd7,
        OP_EQUAL     = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_DUP  = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OUT_RD,
        S_OUT_LD,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_RESULT
    } state_t;

endpackage

FILE: rtl/tsme_ram.sv
// ----------------------------------------------------------------------------
// tsme_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tsme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/two_set_membership_engine_top.sv
// ----------------------------------------------------------------------------
// two_set_membership_engine_top
// two bounded sets of distinct 32-bit integers with insert, membership,
// clear, union/intersection/difference/symmetric difference, subset, equal
// ----------------------------------------------------------------------------
// One command is taken when in_ready is high; in_ready stays low until the
// last result of that command has been loaded into the output register. All
// searching goes through a single 32-bit equality comparator against one slot
// ram read at a time, so time is set by the slot scan: a slot visit takes an
// address state and then a compare state. Insert and member scan the target
// set up to the first match; clear goes straight to its result. A set
// operation walks A checking each element against B, then for union and
// symmetric difference walks B against A, scanning the inner set again for
// each outer element. Subset and equal walk A against B and stop at the
// first miss. Operation codes 9 to 15 are taken and produce no result. Set
// results leave one element per transfer, A first, each in slot order, and
// the output side may stall at any time.
// ----------------------------------------------------------------------------
module two_set_membership_engine_top
    import tsme_pkg::*;
#(
    parameter int SET_CAPACITY = SET_CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [3:0]               operation,
    input  logic                     set_select,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] element,
    output logic                     has_element,
    output logic                     answer,
    output logic [1:0]               status,
    output logic [COUNT_OUT_W-1:0]   count_a,
    output logic [COUNT_OUT_W-1:0]   count_b,
    output logic                     last
);

    localparam int AW    = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int CNT_W = $clog2(SET_CAPACITY + 1);
    localparam int KW    = $clog2(MAX_RESULTS + 1);

    state_t state_reg, state_next;

    op_t                op_reg, op_next;
    logic               scan_b_reg, scan_b_next;     // 1: inner set is B, outer is A
    logic [DATA_W-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic               found_reg, found_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [DATA_W-1:0]  pend_elem_reg, pend_elem_next;
    logic [KW-1:0]      k_reg, k_next;
    logic               ans_reg, ans_next;
    status_t            stat_reg, stat_next;
    logic [CNT_W-1:0]   cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]   cnt_b_reg, cnt_b_next;

    logic                   out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]      out_elem_reg, out_elem_next;
    logic                   out_has_reg, out_has_next;
    logic                   out_ans_reg, out_ans_next;
    logic [1:0]             out_stat_reg, out_stat_next;
    logic [COUNT_OUT_W-1:0] out_cnt_a_reg, out_cnt_a_next;
    logic [COUNT_OUT_W-1:0] out_cnt_b_reg, out_cnt_b_next;
    logic                   out_last_reg, out_last_next;

    logic               in_xfer;
    logic               out_free;
    op_t                op_in;
    logic [CNT_W-1:0]   inner_cnt, outer_cnt, sel_cnt;
    logic [DATA_W-1:0]  a_rdata, b_rdata, inner_data, outer_data;
    logic [AW-1:0]      raddr;
    logic               a_we, b_we;
    logic [AW-1:0]      waddr;
    logic               match;
    logic               is_setop, is_walk, two_phase, emit;
    logic [CNT_W+COUNT_OUT_W-1:0] cnt_a_ext, cnt_b_ext;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign op_in    = op_t'(operation);

    assign inner_cnt  = scan_b_reg ? cnt_b_reg : cnt_a_reg;
    assign outer_cnt  = scan_b_reg ? cnt_a_reg : cnt_b_reg;
    assign sel_cnt    = scan_b_reg ? cnt_b_reg : cnt_a_reg;
    assign inner_data = scan_b_reg ? b_rdata : a_rdata;
    assign outer_data = scan_b_reg ? a_rdata : b_rdata;
    assign match      = (inner_data == key_reg);

    // both rams share one read address: outer index while loading, else scan index
    assign raddr = (state_reg == S_OUT_RD) ? i_reg[AW-1:0] : j_reg[AW-1:0];
    assign waddr = sel_cnt[AW-1:0];

    assign is_setop  = (op_reg == OP_UNION) || (op_reg == OP_INTERSECT) ||
                       (op_reg == OP_A_MINUS_B) || (op_reg == OP_SYMDIFF);
    assign is_walk   = (op_reg == OP_SUBSET) || (op_reg == OP_EQUAL);
    assign two_phase = (op_reg == OP_UNION) || (op_reg == OP_SYMDIFF);

    // second pass (B against A) keeps only elements missing from A
    always_comb
    begin
        if (!scan_b_reg)
        begin
            emit = !found_reg;
        end
        else
        begin
            emit = (op_reg == OP_UNION) ||
                   ((op_reg == OP_INTERSECT) && found_reg) ||
                   (((op_reg == OP_A_MINUS_B) || (op_reg == OP_SYMDIFF)) && !found_reg);
        end
    end

    assign cnt_a_ext = {{COUNT_OUT_W{1'b0}}, cnt_a_reg};
    assign cnt_b_ext = {{COUNT_OUT_W{1'b0}}, cnt_b_reg};

    tsme_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SET_CAPACITY)
    ) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (key_reg),
        .raddr (raddr),
        .rdata (a_rdata)
    );

    tsme_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SET_CAPACITY)
    ) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (key_reg),
        .raddr (raddr),
        .rdata (b_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (op_in)
                        OP_INSERT, OP_MEMBER:
                            state_next = S_SCAN_RD;
                        OP_CLEAR:
                            state_next = S_RESULT;
                        OP_UNION, OP_INTERSECT, OP_A_MINUS_B, OP_SYMDIFF, OP_SUBSET:
                            state_next = S_OUT_RD;
                        OP_EQUAL:
                            state_next = (cnt_a_reg != cnt_b_reg) ? S_RESULT : S_OUT_RD;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_OUT_RD:
            begin
                if (i_reg >= outer_cnt)
                begin
                    if (is_setop && scan_b_reg && two_phase)
                    begin
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
                else
                begin
                    state_next = S_OUT_LD;
                end
            end
            S_OUT_LD:
                state_next = S_SCAN_RD;
            S_SCAN_RD:
                state_next = (j_reg >= inner_cnt) ? S_DECIDE : S_SCAN_CMP;
            S_SCAN_CMP:
                state_next = match ? S_DECIDE : S_SCAN_RD;
            S_DECIDE:
            begin
                if (is_setop)
                begin
                    if (emit && pend_valid_reg && !out_free)
                    begin
                        state_next = S_DECIDE;
                    end
                    else if (emit && (k_reg == KW'(MAX_RESULTS - 1)))
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_OUT_RD;
                    end
                end
                else if (is_walk)
                begin
                    state_next = found_reg ? S_OUT_RD : S_RESULT;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
                state_next = out_free ? S_IDLE : S_RESULT;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and output register
    always_comb
    begin
        op_next         = op_reg;
        scan_b_next     = scan_b_reg;
        key_next        = key_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_elem_next  = pend_elem_reg;
        k_next          = k_reg;
        ans_next        = ans_reg;
        stat_next       = stat_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        a_we            = 1'b0;
        b_we            = 1'b0;

        out_valid_next  = out_valid_reg && !out_ready;
        out_elem_next   = out_elem_reg;
        out_has_next    = out_has_reg;
        out_ans_next    = out_ans_reg;
        out_stat_next   = out_stat_reg;
        out_cnt_a_next  = out_cnt_a_reg;
        out_cnt_b_next  = out_cnt_b_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next         = op_in;
                    key_next        = value;
                    i_next          = '0;
                    j_next          = '0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    k_next          = '0;
                    ans_next        = 1'b0;
                    stat_next       = STAT_OK;
                    unique case (op_in)
                        OP_INSERT, OP_MEMBER:
                            scan_b_next = set_select;
                        OP_CLEAR:
                        begin
                            if (set_select)
                            begin
                                cnt_b_next = '0;
                            end
                            else
                            begin
                                cnt_a_next = '0;
                            end
                        end
                        default:
                            scan_b_next = 1'b1;
                    endcase
                end
            end
            S_OUT_RD:
            begin
                if (i_reg >= outer_cnt)
                begin
                    if (is_setop && scan_b_reg && two_phase)
                    begin
                        scan_b_next = 1'b0;
                        i_next      = '0;
                    end
                    else if (is_walk)
                    begin
                        ans_next = 1'b1;
                    end
                end
            end
            S_OUT_LD:
            begin
                key_next = outer_data;
                j_next   = '0;
            end
            S_SCAN_RD:
            begin
                if (j_reg >= inner_cnt)
                begin
                    found_next = 1'b0;
                end
            end
            S_SCAN_CMP:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_DECIDE:
            begin
                if (is_setop)
                begin
                    if (!(emit && pend_valid_reg && !out_free))
                    begin
                        i_next = i_reg + 1'b1;
                        if (emit)
                        begin
                            // previous element is known not to be the last one now
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_elem_next  = pend_elem_reg;
                                out_has_next   = 1'b1;
                                out_ans_next   = 1'b0;
                                out_stat_next  = STAT_OK;
                                out_cnt_a_next = cnt_a_ext[COUNT_OUT_W-1:0];
                                out_cnt_b_next = cnt_b_ext[COUNT_OUT_W-1:0];
                                out_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_elem_next  = key_reg;
                            k_next          = k_reg + 1'b1;
                        end
                    end
                end
                else if (is_walk)
                begin
                    i_next = i_reg + 1'b1;
                end
                else if (op_reg == OP_MEMBER)
                begin
                    ans_next = found_reg;
                end
                else
                begin
                    // insert: duplicate wins over full
                    if (found_reg)
                    begin
                        stat_next = STAT_DUP;
                    end
                    else if (sel_cnt >= CNT_W'(SET_CAPACITY))
                    begin
                        stat_next = STAT_FULL;
                    end
                    else
                    begin
                        ans_next = 1'b1;
                        if (scan_b_reg)
                        begin
                            b_we       = 1'b1;
                            cnt_b_next = cnt_b_reg + 1'b1;
                        end
                        else
                        begin
                            a_we       = 1'b1;
                            cnt_a_next = cnt_a_reg + 1'b1;
                        end
                    end
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cnt_a_next = cnt_a_ext[COUNT_OUT_W-1:0];
                    out_cnt_b_next = cnt_b_ext[COUNT_OUT_W-1:0];
                    out_last_next  = 1'b1;
                    if (is_setop)
                    begin
                        out_elem_next = pend_valid_reg ? pend_elem_reg : '0;
                        out_has_next  = pend_valid_reg;
                        out_ans_next  = 1'b0;
                        out_stat_next = STAT_OK;
                    end
                    else
                    begin
                        out_elem_next = '0;
                        out_has_next  = 1'b0;
                        out_ans_next  = ans_reg;
                        out_stat_next = stat_reg;
                    end
                end
            end
            default:
            begin
                op_next = op_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        scan_b_reg     <= scan_b_next;
        key_reg        <= key_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        found_reg      <= found_next;
        pend_valid_reg <= pend_valid_next;
        pend_elem_reg  <= pend_elem_next;
        k_reg          <= k_next;
        ans_reg        <= ans_next;
        stat_reg       <= stat_next;
        out_elem_reg   <= out_elem_next;
        out_has_reg    <= out_has_next;
        out_ans_reg    <= out_ans_next;
        out_stat_reg   <= out_stat_next;
        out_cnt_a_reg  <= out_cnt_a_next;
        out_cnt_b_reg  <= out_cnt_b_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign element     = out_elem_reg;
    assign has_element = out_has_reg;
    assign answer      = out_ans_reg;
    assign status      = out_stat_reg;
    assign count_a     = out_cnt_a_reg;
    assign count_b     = out_cnt_b_reg;
    assign last        = out_last_reg;

endmodule

FILE: tb/tb_two_set_membership_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_set_membership_engine_top
// self-checking bench for the two-set membership engine: directed corner
// cases, completely filled sets and random insert/query/set-operation
// sequences, checked against an in-bench predictor under handshake pressure
// ----------------------------------------------------------------------------
module tb_two_set_membership_engine_top
    import tsme_pkg::*;
();

    localparam int CAP       = SET_CAPACITY_DEF;
    localparam int POOL_SIZE = 24;

    typedef struct {
        logic signed [DATA_W-1:0] element;
        logic                     has_element;
        logic                     answer;
        logic [1:0]               status;
        logic [COUNT_OUT_W-1:0]   count_a;
        logic [COUNT_OUT_W-1:0]   count_b;
        logic                     last;
    } result_t;

    logic                     clk;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic [3:0]               operation   = '0;
    logic                     set_select  = 1'b0;
    logic signed [DATA_W-1:0] value       = '0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic signed [DATA_W-1:0] element;
    logic                     has_element;
    logic                     answer;
    logic [1:0]               status;
    logic [COUNT_OUT_W-1:0]   count_a;
    logic [COUNT_OUT_W-1:0]   count_b;
    logic                     last;

    // predictor copy of the two sets
    logic [DATA_W-1:0] a_slots [CAP];
    logic [DATA_W-1:0] b_slots [CAP];
    int unsigned       a_cnt = 0;
    int unsigned       b_cnt = 0;

    result_t           pending_results [$];
    logic [DATA_W-1:0] value_pool [POOL_SIZE];

    int send_pct      = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int results_seen  = 0;
    int commands_sent = 0;
    int full_rejects  = 0;
    int dup_rejects   = 0;
    int set_elements  = 0;

    two_set_membership_engine_top #(
        .SET_CAPACITY(CAP)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .set_select  (set_select),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .element     (element),
        .has_element (has_element),
        .answer      (answer),
        .status      (status),
        .count_a     (count_a),
        .count_b     (count_b),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic bit in_set(bit use_b, logic [DATA_W-1:0] v);
        int unsigned n = use_b ? b_cnt : a_cnt;
        for (int i = 0; i < n && i < CAP; i++)
            if ((use_b ? b_slots[i] : a_slots[i]) == v)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit a_within_b();
        for (int i = 0; i < a_cnt && i < CAP; i++)
            if (!in_set(1'b1, a_slots[i]))
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic result_t blank_result();
        result_t r;
        r.element     = '0;
        r.has_element = 1'b0;
        r.answer      = 1'b0;
        r.status      = STAT_OK;
        r.count_a     = a_cnt[COUNT_OUT_W-1:0];
        r.count_b     = b_cnt[COUNT_OUT_W-1:0];
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic string describe_result(result_t r);
        return $sformatf("elem=%0d has=%0b ans=%0b st=%0d a=%0d b=%0d last=%0b",
                         r.element, r.has_element, r.answer, r.status,
                         r.count_a, r.count_b, r.last);
    endfunction

    task automatic note_failure(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d at %0t: %s", mismatches, $time, what);
    endtask

    // works out the results one command causes and queues them
    task automatic predict_results(logic [3:0] op, logic sel, logic [DATA_W-1:0] v);
        result_t     batch [$];
        result_t     r;
        logic [1:0]  st;
        bit          ans;
        bit          inb;
        int unsigned tgt_cnt;
        tgt_cnt = sel ? b_cnt : a_cnt;
        st      = STAT_OK;
        ans     = 1'b0;
        case (op)
            OP_INSERT:
            begin
                if (in_set(sel, v))
                begin
                    st = STAT_DUP;
                    dup_rejects++;
                end
                else if (tgt_cnt >= CAP)
                begin
                    st = STAT_FULL;
                    full_rejects++;
                end
                else
                begin
                    if (sel)
                    begin
                        b_slots[b_cnt] = v;
                        b_cnt++;
                    end
                    else
                    begin
                        a_slots[a_cnt] = v;
                        a_cnt++;
                    end
                    ans = 1'b1;
                end
                r        = blank_result();
                r.answer = ans;
                r.status = st;
                batch.push_back(r);
            end
            OP_MEMBER:
            begin
                r        = blank_result();
                r.answer = in_set(sel, v);
                batch.push_back(r);
            end
            OP_CLEAR:
            begin
                if (sel)
                    b_cnt = 0;
                else
                    a_cnt = 0;
                batch.push_back(blank_result());
            end
            OP_UNION, OP_INTERSECT, OP_A_MINUS_B, OP_SYMDIFF:
            begin
                for (int i = 0; i < a_cnt && i < CAP; i++)
                begin
                    inb = in_set(1'b1, a_slots[i]);
                    if ((op == OP_UNION || (op == OP_INTERSECT && inb)
                         || ((op == OP_A_MINUS_B || op == OP_SYMDIFF) && !inb))
                        && batch.size() < MAX_RESULTS)
                    begin
                        r             = blank_result();
                        r.element     = a_slots[i];
                        r.has_element = 1'b1;
                        batch.push_back(r);
                    end
                end
                if (op == OP_UNION || op == OP_SYMDIFF)
                begin
                    for (int i = 0; i < b_cnt && i < CAP; i++)
                    begin
                        if (!in_set(1'b0, b_slots[i]) && batch.size() < MAX_RESULTS)
                        begin
                            r             = blank_result();
                            r.element     = b_slots[i];
                            r.has_element = 1'b1;
                            batch.push_back(r);
                        end
                    end
                end
                set_elements += batch.size();
                // empty result still produces one marker transfer
                if (batch.size() == 0)
                    batch.push_back(blank_result());
            end
            OP_SUBSET:
            begin
                r        = blank_result();
                r.answer = a_within_b();
                batch.push_back(r);
            end
            OP_EQUAL:
            begin
                r        = blank_result();
                r.answer = (a_cnt == b_cnt) && a_within_b();
                batch.push_back(r);
            end
            default:
            begin
            end
        endcase
        if (batch.size() != 0)
        begin
            batch[batch.size()-1].last = 1'b1;
            for (int i = 0; i < batch.size(); i++)
                pending_results.push_back(batch[i]);
        end
    endtask

    // valid stays up between back-to-back commands, only dropped for a gap
    task automatic send_command(logic [3:0] op, logic sel, logic [DATA_W-1:0] v);
        bit took;
        if (send_pct != 0 && $urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_pct);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        set_select <= sel;
        value      <= v;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
        predict_results(op, sel, v);
        if (op <= OP_EQUAL)
            commands_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    always @(negedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.element     = element;
            got.has_element = has_element;
            got.answer      = answer;
            got.status      = status;
            got.count_a     = count_a;
            got.count_b     = count_b;
            got.last        = last;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                note_failure($sformatf("unexpected transfer %s", describe_result(got)));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.element !== want.element || got.has_element !== want.has_element
                    || got.answer !== want.answer || got.status !== want.status
                    || got.count_a !== want.count_a || got.count_b !== want.count_b
                    || got.last !== want.last)
                    note_failure($sformatf("expected %s, got %s",
                                           describe_result(want), describe_result(got)));
            end
        end
    end

    task automatic test_directed_cases();
        send_pct  = 0;
        stall_pct = 0;
        // empty sets: empty marker, empty A is subset and equal
        send_command(OP_UNION, 1'b0, 32'h0);
        send_command(OP_SUBSET, 1'b1, 32'h0);
        send_command(OP_EQUAL, 1'b0, 32'h0);
        send_command(OP_MEMBER, 1'b0, 32'h0);
        send_command(OP_INSERT, 1'b0, 32'h8000_0000);
        send_command(OP_INSERT, 1'b0, 32'h7FFF_FFFF);
        send_command(OP_INSERT, 1'b0, 32'h0000_0000);
        send_command(OP_INSERT, 1'b0, 32'hFFFF_FFFF);
        send_command(OP_INSERT, 1'b0, 32'h7FFF_FFFF);
        send_command(OP_INSERT, 1'b1, 32'h7FFF_FFFF);
        send_command(OP_INSERT, 1'b1, 32'h5555_AAAA);
        send_command(OP_MEMBER, 1'b0, 32'hFFFF_FFFF);
        send_command(OP_MEMBER, 1'b1, 32'h0000_0000);
        send_command(OP_UNION, 1'b1, 32'hFFFF_FFFF);
        send_command(OP_INTERSECT, 1'b0, 32'h0);
        send_command(OP_A_MINUS_B, 1'b1, 32'h0);
        send_command(OP_SYMDIFF, 1'b0, 32'h0);
        send_command(OP_SUBSET, 1'b0, 32'h0);
        send_command(OP_EQUAL, 1'b1, 32'h0);
        // codes past the last operation are taken silently
        send_command(4'd9, 1'b1, 32'h1234_5678);
        send_command(4'd15, 1'b1, 32'hFFFF_FFFF);
        send_command(OP_CLEAR, 1'b0, 32'h0);
        send_command(OP_INTERSECT, 1'b0, 32'h0);
        send_command(OP_SUBSET, 1'b0, 32'h0);
        send_command(OP_EQUAL, 1'b0, 32'h0);
        send_command(OP_CLEAR, 1'b1, 32'h0);
        send_command(OP_EQUAL, 1'b0, 32'h0);
        wait_drained();
    endtask

    task automatic test_full_sets();
        send_pct  = 0;
        stall_pct = 74;
        send_command(OP_CLEAR, 1'b0, $urandom);
        send_command(OP_CLEAR, 1'b1, $urandom);
        while (a_cnt < CAP)
            send_command(OP_INSERT, 1'b0, $urandom);
        while (b_cnt < CAP)
            send_command(OP_INSERT, 1'b1, $urandom);
        send_command(OP_INSERT, 1'b0, $urandom);
        // duplicate wins over full
        send_command(OP_INSERT, 1'b0, a_slots[3]);
        send_command(OP_INSERT, 1'b1, b_slots[CAP-1]);
        send_command(OP_UNION, 1'b0, $urandom);
        send_command(OP_SYMDIFF, 1'b1, $urandom);
        send_command(OP_INTERSECT, 1'b0, $urandom);
        send_command(OP_A_MINUS_B, 1'b1, $urandom);
        send_command(OP_SUBSET, 1'b0, $urandom);
        send_command(OP_EQUAL, 1'b1, $urandom);
        send_command(OP_MEMBER, 1'b0, a_slots[CAP-1]);
        send_command(OP_MEMBER, 1'b1, a_slots[0]);
        // hold off until the big results are all out
        wait_drained();
        // B becomes A in reverse slot order
        send_command(OP_CLEAR, 1'b1, $urandom);
        for (int i = CAP - 1; i >= 0; i--)
            send_command(OP_INSERT, 1'b1, a_slots[i]);
        send_command(OP_EQUAL, 1'b0, $urandom);
        send_command(OP_SUBSET, 1'b1, $urandom);
        send_command(OP_INTERSECT, 1'b0, $urandom);
        send_command(OP_SYMDIFF, 1'b1, $urandom);
        send_command(OP_UNION, 1'b0, $urandom);
        wait_drained();
    endtask

    task automatic test_random_sequences();
        logic [DATA_W-1:0] picked [$];
        logic [DATA_W-1:0] v;
        logic [3:0]        op;
        int                goal;
        int                k;
        int                pick;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_pct = 0;  stall_pct = 0;  end
                1:       begin send_pct = 74; stall_pct = 0;  end
                2:       begin send_pct = 0;  stall_pct = 74; end
                default: begin send_pct = 15; stall_pct = 15; end
            endcase
            goal = commands_sent + 12;
            while (commands_sent < goal)
            begin
                pick = $urandom_range(9);
                if (pick < 4)
                begin
                    // build related sets, then compare them
                    send_command(OP_CLEAR, 1'b0, $urandom);
                    send_command(OP_CLEAR, 1'b1, $urandom);
                    picked.delete();
                    k = $urandom_range(5);
                    repeat (k)
                        picked.push_back(value_pool[$urandom_range(POOL_SIZE-1)]);
                    for (int i = 0; i < k; i++)
                        send_command(OP_INSERT, 1'b0, picked[i]);
                    for (int i = k - 1; i >= 0; i--)
                        if ($urandom_range(4) != 0)
                            send_command(OP_INSERT, 1'b1, picked[i]);
                    if ($urandom_range(1))
                        send_command(OP_INSERT, 1'b1, value_pool[$urandom_range(POOL_SIZE-1)]);
                    send_command(OP_SUBSET, 1'($urandom_range(1)), $urandom);
                    send_command(OP_EQUAL, 1'($urandom_range(1)), $urandom);
                    send_command(4'($urandom_range(OP_UNION, OP_SYMDIFF)),
                                 1'($urandom_range(1)), $urandom);
                end
                else if (pick < 9)
                begin
                    k = $urandom_range(99);
                    if (k < 40)
                        op = OP_INSERT;
                    else if (k < 55)
                        op = OP_MEMBER;
                    else if (k < 60)
                        op = OP_CLEAR;
                    else if (k < 80)
                        op = 4'($urandom_range(OP_UNION, OP_SYMDIFF));
                    else if (k < 90)
                        op = OP_SUBSET;
                    else
                        op = OP_EQUAL;
                    v = ($urandom_range(4) == 0) ? $urandom
                                                 : value_pool[$urandom_range(POOL_SIZE-1)];
                    send_command(op, 1'($urandom_range(1)), v);
                end
                else
                begin
                    send_command(4'($urandom_range(9, 15)), 1'($urandom_range(1)), $urandom);
                end
            end
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_full_sets();
        test_random_sequences();
        in_valid <= 1'b0;
        for (int guard = 0; guard < 200000 && pending_results.size() != 0; guard++)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));
        $display("ran %0d commands, %0d result transfers, %0d set elements",
                 commands_sent, results_seen, set_elements);
        $display("rejections: %0d duplicate, %0d full; four sender/receiver pressure mixes",
                 dup_rejects, full_rejects);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
